### hw/rtl/rdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdg_pkg: shared types and constants of the RGB565 to gray downscaler
// Frame dimension limits, counter widths, luma weights and the structs that
// travel between the sampler and the top level.
// ----------------------------------------------------------------------------
package rdg_pkg;

  // Largest frame dimension that the counters support.
  localparam int MAX_DIM = 1024;

  // Width of a configuration register and of the configuration data bus.
  localparam int CFG_W   = 11;
  // Number of configuration registers and the width of their index.
  localparam int NUM_REGS = 4;
  localparam int IDX_W    = $clog2(NUM_REGS);

  // A dimension holds 1..MAX_DIM; a source position holds 0..MAX_DIM-1.
  localparam int DIM_W = $clog2(MAX_DIM) + 1;
  localparam int CNT_W = $clog2(MAX_DIM);
  // Error accumulators stay below twice the largest dimension.
  localparam int ERR_W = DIM_W + 1;

  // Register indexes of the configuration port.
  typedef enum logic [IDX_W-1:0] {
    REG_SOURCE_WIDTH  = IDX_W'(0),
    REG_SOURCE_HEIGHT = IDX_W'(1),
    REG_TARGET_WIDTH  = IDX_W'(2),
    REG_TARGET_HEIGHT = IDX_W'(3)
  } rdg_reg_t;

  // Register reset value shared by all four dimensions.
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(96);

  // Luma weights, scaled by 2^LUMA_SHIFT.
  localparam int LUMA_R     = 305;
  localparam int LUMA_G     = 600;
  localparam int LUMA_B     = 119;
  localparam int LUMA_SHIFT = 10;
  // Weighted sum of three 8-bit channels fits in this many bits.
  localparam int SUM_W      = 18;

  // Offset that turns unsigned luma into a signed byte.
  localparam logic [7:0] GRAY_OFFSET = 8'h80;

  // Effective frame dimensions after clamping.
  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] tgt_w;
    logic [DIM_W-1:0] tgt_h;
  } rdg_dims_t;

  // Sampling decision for the beat being accepted.
  typedef struct packed {
    logic pick;
    logic last;
  } rdg_pick_t;

  // Clamp a raw register value into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

### hw/rtl/rdg_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdg_luma: byte-swapped RGB565 unpack and luma conversion
// Expands the packed pixel to 8-bit R, G and B and forms the weighted sum
// (305R + 600G + 119B) >> 10 as an 8-bit luma value.
// ----------------------------------------------------------------------------
module rdg_luma
  import rdg_pkg::*;
(
  input  logic [15:0] pixel_word,
  output logic [7:0]  luma
);

  logic [7:0]       lo_byte;
  logic [7:0]       hi_byte;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic [SUM_W-1:0] sum;

  // Bytes arrive swapped: the high byte holds G low bits and R.
  assign lo_byte = pixel_word[7:0];
  assign hi_byte = pixel_word[15:8];

  // Unpack into 8-bit channels with zero fill in the low bits.
  assign red   = {hi_byte[4:0], 3'b000};
  assign green = {lo_byte[2:0], hi_byte[7:5], 2'b00};
  assign blue  = {lo_byte[7:3], 3'b000};

  // Constant-weight sum; each product is a few shifted adds.
  assign sum = SUM_W'(LUMA_R) * SUM_W'(red)
             + SUM_W'(LUMA_G) * SUM_W'(green)
             + SUM_W'(LUMA_B) * SUM_W'(blue);

  assign luma = sum[LUMA_SHIFT +: 8];

endmodule

### hw/rtl/rdg_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdg_sampler: nearest-neighbor position tracking
// Tracks the source and target positions and the row and column error
// accumulators, and decides for each accepted beat whether it is sampled.
// ----------------------------------------------------------------------------
module rdg_sampler
  import rdg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      restart,
  input  logic      advance,
  input  rdg_dims_t dims,
  output rdg_pick_t pick
);

  logic [CNT_W-1:0] src_col_r, src_col_nxt;
  logic [CNT_W-1:0] src_row_r, src_row_nxt;
  logic [DIM_W-1:0] out_col_r, out_col_nxt;
  logic [DIM_W-1:0] out_row_r, out_row_nxt;
  logic [ERR_W-1:0] col_err_r, col_err_nxt;
  logic [ERR_W-1:0] row_err_r, row_err_nxt;

  logic             row_pick;
  logic             col_pick;
  logic [DIM_W-1:0] out_col_inc;
  logic [DIM_W-1:0] out_row_inc;
  logic [ERR_W-1:0] col_err_inc;
  logic [ERR_W-1:0] row_err_inc;
  logic [ERR_W-1:0] tgt_w_ext;
  logic [ERR_W-1:0] tgt_h_ext;
  logic             row_end;
  logic             frame_end;

  assign tgt_w_ext = ERR_W'(dims.tgt_w);
  assign tgt_h_ext = ERR_W'(dims.tgt_h);

  // Sample decision for the current source position.
  assign row_pick = (out_row_r < dims.tgt_h) && (row_err_r < tgt_h_ext);
  assign col_pick = row_pick && (out_col_r < dims.tgt_w) && (col_err_r < tgt_w_ext);

  assign pick.pick = col_pick;
  assign pick.last = (out_col_r == dims.tgt_w - DIM_W'(1)) &&
                     (out_row_r == dims.tgt_h - DIM_W'(1));

  // Column state after a possible sample.
  assign out_col_inc = out_col_r + DIM_W'(col_pick);
  assign col_err_inc = col_pick ? col_err_r + ERR_W'(dims.src_w) : col_err_r;

  // Row state after a possible row sample.
  assign out_row_inc = out_row_r + DIM_W'(row_pick);
  assign row_err_inc = row_pick ? row_err_r + ERR_W'(dims.src_h) : row_err_r;

  assign row_end   = (DIM_W'(src_col_r) + DIM_W'(1)) >= dims.src_w;
  assign frame_end = (DIM_W'(src_row_r) + DIM_W'(1)) >= dims.src_h;

  // Next position for each accepted beat, or back to the start on restart.
  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    col_err_nxt = col_err_r;
    row_err_nxt = row_err_r;
    if (restart) begin
      src_col_nxt = '0;
      src_row_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      col_err_nxt = '0;
      row_err_nxt = '0;
    end else if (advance) begin
      if (row_end) begin
        src_col_nxt = '0;
        out_col_nxt = '0;
        col_err_nxt = '0;
        if (frame_end) begin
          // Last source pixel of the frame: start over.
          src_row_nxt = '0;
          out_row_nxt = '0;
          row_err_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + CNT_W'(1);
          out_row_nxt = out_row_inc;
          if (out_row_inc < dims.tgt_h) begin
            row_err_nxt = (row_err_inc >= tgt_h_ext) ? row_err_inc - tgt_h_ext : '0;
          end else begin
            row_err_nxt = row_err_inc;
          end
        end
      end else begin
        src_col_nxt = src_col_r + CNT_W'(1);
        out_col_nxt = out_col_inc;
        if (out_col_inc < dims.tgt_w) begin
          col_err_nxt = (col_err_inc >= tgt_w_ext) ? col_err_inc - tgt_w_ext : '0;
        end else begin
          col_err_nxt = col_err_inc;
        end
      end
    end
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      col_err_r <= '0;
      row_err_r <= '0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      col_err_r <= col_err_nxt;
      row_err_r <= row_err_nxt;
    end
  end

endmodule

### hw/rtl/rgb565_downscale_to_gray.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_downscale_to_gray: nearest-neighbor downscaler to signed grayscale
// Source pixels enter in raster order as byte-swapped RGB565 words. Selected
// pixels leave as luma minus 128 in a signed byte, with an end-of-frame flag.
//
// Channels: the input beat (in_valid, in_stall, in_pixel_word) carries one
// source pixel; the output beat (out_valid, out_stall, out_gray_value,
// out_frame_done) carries one target pixel. A beat moves on a rising edge
// with valid high and stall low. Source pixels that are not sampled give no
// output beat.
// A sampled pixel shows on the output in the cycle after it is accepted.
// Throughput is one pixel per cycle unless in_stall holds the input; the
// single output register sets it, and a new pixel is taken in the same
// cycle that the waiting result leaves.
// While the receiver stalls with a result waiting, in_stall is raised and
// the output holds. Reset sets all dimensions to 96 and the frame position
// to its start; any configuration write also restarts the frame. Write
// configuration only with no beat in flight.
// ----------------------------------------------------------------------------
module rgb565_downscale_to_gray
  import rdg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  // Source pixel channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_pixel_word,
  // Gray pixel channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_gray_value,
  output logic              out_frame_done
);

  logic [CFG_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;

  logic               out_valid_r, out_valid_nxt;
  logic signed [7:0]  gray_r, gray_nxt;
  logic               done_r, done_nxt;

  logic [DIM_W-1:0] src_w_c, src_h_c, tgt_w_c, tgt_h_c;
  rdg_dims_t        dims;
  rdg_pick_t        pick;
  logic [7:0]       luma;
  logic             in_accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_RESET;
      src_h_r <= DIM_RESET;
      tgt_w_r <= DIM_RESET;
      tgt_h_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (rdg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  src_w_r <= cfg_wr_data;
        REG_SOURCE_HEIGHT: src_h_r <= cfg_wr_data;
        REG_TARGET_WIDTH:  tgt_w_r <= cfg_wr_data;
        REG_TARGET_HEIGHT: tgt_h_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clamp dimensions; the target never exceeds the source.
  assign src_w_c = clamp_dim(src_w_r);
  assign src_h_c = clamp_dim(src_h_r);
  assign tgt_w_c = clamp_dim(tgt_w_r);
  assign tgt_h_c = clamp_dim(tgt_h_r);

  assign dims.src_w = src_w_c;
  assign dims.src_h = src_h_c;
  assign dims.tgt_w = (tgt_w_c > src_w_c) ? src_w_c : tgt_w_c;
  assign dims.tgt_h = (tgt_h_c > src_h_c) ? src_h_c : tgt_h_c;

  // Hold the input only while a result waits on a stalled output.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  rdg_sampler u_sampler (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr_en),
    .advance (in_accept),
    .dims    (dims),
    .pick    (pick)
  );

  rdg_luma u_luma (
    .pixel_word (in_pixel_word),
    .luma       (luma)
  );

  // Output register next state.
  always_comb begin
    out_valid_nxt = out_valid_r;
    gray_nxt      = gray_r;
    done_nxt      = done_r;
    if (in_accept) begin
      out_valid_nxt = pick.pick;
      if (pick.pick) begin
        gray_nxt = signed'(luma ^ GRAY_OFFSET);
        done_nxt = pick.last;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gray_r <= gray_nxt;
    done_r <= done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_gray_value = gray_r;
  assign out_frame_done = done_r;

endmodule
